// File: hdl/spd_pkg.sv
package spd_pkg;

    localparam logic [7:0] PctChar  = 8'h25;
    localparam logic [7:0] Digit0   = 8'h30;
    localparam logic [7:0] LetterA  = 8'h57;
    localparam logic [7:0] CaseBit  = 8'h20;

    localparam int unsigned OutMax  = 3;

    typedef logic [1:0] char_class_t;

    localparam char_class_t ClassAlways = 2'd0;
    localparam char_class_t ClassMore   = 2'd1;
    localparam char_class_t ClassNever  = 2'd2;

    localparam char_class_t CharClass [128] = '{
        2,2,2,2,2,2,2,2,2,2,2,2,2,2,2,2,
        2,2,2,2,2,2,2,2,2,2,2,2,2,2,2,2,
        0,0,2,0,0,2,1,1,0,0,0,1,0,0,0,0,
        0,0,0,0,0,0,0,0,0,0,0,1,1,0,1,0,
        0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,
        0,0,0,0,0,0,0,0,0,0,0,0,2,0,0,0,
        1,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,
        0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,2
    };

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - Digit0;
        end else begin
            d = (c | CaseBit) - LetterA;
        end
        return d[3:0];
    endfunction

endpackage

// File: hdl/selective_percent_decoder.sv
// Percent-escape decoder for a byte stream.
// Input channel s_*: one raw byte per transfer in s_tdata, s_tlast on the
// final byte of a string. Output channel m_*: decoded bytes, m_tlast on the
// final output byte of each string.
// A '%' plus two hex digits becomes the encoded byte when that byte is
// below 0x80 and its class allows it; cfg_we/cfg_wdata set the decode_more
// bit; the user must write it only while the block is idle (not enforced).
// The first result of an input byte is on m_* in the cycle after the
// input transfer. An input byte yields zero to three results, held in a
// three-entry result register and sent one per cycle while m_tready is high.
// Throughput: one byte per cycle while each byte yields at most one result
// and m_tready is high; a byte that yields more results holds s_tready low
// until the single output port has drained the result register to its last entry.
// Reset (aresetn low, synchronous) drops any pending escape, empties the
// result register and clears decode_more.
// When the receiver stalls, the result register holds and s_tready drops
// as soon as the next byte could not be stored.
module selective_percent_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast
);
    import spd_pkg::*;

    logic       decode_more_reg;
    logic [1:0] pend_reg, pend_next;
    logic [7:0] first_reg, first_next;
    logic [7:0] buf_reg [OutMax];
    logic [1:0] cnt_reg;
    logic       last_reg;

    logic [7:0]  ob [OutMax];
    logic [1:0]  n;
    logic        s_xfer, m_xfer;
    logic [7:0]  dec;
    char_class_t cls;
    logic        allow;

    assign s_xfer   = s_tvalid && s_tready;
    assign m_xfer   = m_tvalid && m_tready;
    assign s_tready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_tready);
    assign m_tvalid = cnt_reg != 2'd0;
    assign m_tdata  = buf_reg[0];
    assign m_tlast  = last_reg && cnt_reg == 2'd1;

    assign dec   = {hex_val(first_reg), hex_val(s_tdata)};
    assign cls   = dec[7] ? ClassNever : CharClass[dec[6:0]];
    assign allow = cls == ClassAlways || (cls == ClassMore && decode_more_reg);

    always_comb begin
        logic fresh;
        fresh = 1'b0;
        n = 2'd0;
        for (int i = 0; i < OutMax; i++) begin
            ob[i] = 8'd0;
        end
        pend_next  = 2'd0;
        first_next = first_reg;
        case (pend_reg)
            2'd1: begin
                if (is_hex(s_tdata) && !s_tlast) begin
                    first_next = s_tdata;
                    pend_next  = 2'd2;
                end else if (is_hex(s_tdata)) begin
                    ob[0] = PctChar;
                    ob[1] = s_tdata;
                    n     = 2'd2;
                end else begin
                    ob[0] = PctChar;
                    n     = 2'd1;
                    fresh = 1'b1;
                end
            end
            2'd2: begin
                if (is_hex(s_tdata)) begin
                    if (allow) begin
                        ob[0] = dec;
                        n     = 2'd1;
                    end else begin
                        ob[0] = PctChar;
                        ob[1] = first_reg;
                        ob[2] = s_tdata;
                        n     = 2'd3;
                    end
                end else begin
                    ob[0] = PctChar;
                    ob[1] = first_reg;
                    n     = 2'd2;
                    fresh = 1'b1;
                end
            end
            default: begin
                fresh = 1'b1;
            end
        endcase
        if (fresh) begin
            if (s_tdata == PctChar && !s_tlast) begin
                pend_next = 2'd1;
            end else begin
                ob[n] = s_tdata;
                n     = n + 2'd1;
            end
        end
        if (s_tlast) begin
            pend_next = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decode_more_reg <= 1'b0;
            pend_reg        <= 2'd0;
            first_reg       <= 8'd0;
            cnt_reg         <= 2'd0;
            last_reg        <= 1'b0;
        end else begin
            if (cfg_we) begin
                decode_more_reg <= cfg_wdata;
            end
            if (s_xfer) begin
                pend_reg  <= pend_next;
                first_reg <= first_next;
                cnt_reg   <= n;
                last_reg  <= s_tlast;
            end else if (m_xfer) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    // load on input transfer, else advance on output transfer
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            buf_reg <= ob;
        end else if (m_xfer) begin
            buf_reg[0] <= buf_reg[1];
            buf_reg[1] <= buf_reg[2];
        end
    end

    a_pend_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg != 2'd3) else $error("escape count out of range");

    a_pend_hex: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg == 2'd2 |-> is_hex(first_reg)) else $error("held digit not hex");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && s_tlast |=> pend_reg == 2'd0 && cnt_reg != 2'd0)
        else $error("end of string left escape pending or no result");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed under stall");

endmodule

// File: bench/selective_percent_decoder_checker.sv
module selective_percent_decoder_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       m_tlast,
    output int         mismatch_count,
    output int         results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    import spd_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_byte_t;

    out_byte_t  owed_q[$];
    logic       decode_more;
    logic [1:0] esc_held;
    logic [7:0] esc_digit;

    initial begin
        mismatch_count = 0;
        results_owed   = 0;
        decode_more    = 1'b0;
        esc_held       = 2'd0;
        esc_digit      = 8'h00;
    end

    function automatic logic is_hex_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    function automatic logic [3:0] nibble(input logic [7:0] c);
        logic [7:0] lc;
        lc = c | CaseBit;
        return (c <= 8'h39) ? c[3:0] : 4'(lc - LetterA);
    endfunction

    task automatic decode_transfer(input logic [7:0] b, input logic last);
        out_byte_t   res[3];
        int          n;
        logic [1:0]  held;
        logic        fresh;
        logic [7:0]  code;
        char_class_t cls;
        held     = esc_held;
        esc_held = 2'd0;
        n        = 0;
        fresh    = 1'b0;
        case (held)
            2'd1: begin
                if (is_hex_digit(b) && !last) begin
                    esc_digit = b;
                    esc_held  = 2'd2;
                end else if (is_hex_digit(b)) begin
                    res[0] = '{data: PctChar, last: 1'b0};
                    res[1] = '{data: b, last: 1'b0};
                    n = 2;
                end else begin
                    res[0] = '{data: PctChar, last: 1'b0};
                    n = 1;
                    fresh = 1'b1;
                end
            end
            2'd2: begin
                if (is_hex_digit(b)) begin
                    code = {nibble(esc_digit), nibble(b)};
                    cls  = code[7] ? ClassNever : CharClass[code[6:0]];
                    if (cls == ClassAlways || (cls == ClassMore && decode_more)) begin
                        res[0] = '{data: code, last: 1'b0};
                        n = 1;
                    end else begin
                        res[0] = '{data: PctChar, last: 1'b0};
                        res[1] = '{data: esc_digit, last: 1'b0};
                        res[2] = '{data: b, last: 1'b0};
                        n = 3;
                    end
                end else begin
                    res[0] = '{data: PctChar, last: 1'b0};
                    res[1] = '{data: esc_digit, last: 1'b0};
                    n = 2;
                    fresh = 1'b1;
                end
            end
            default: begin
                fresh = 1'b1;
            end
        endcase
        if (fresh) begin
            if (b == PctChar && !last) begin
                esc_held = 2'd1;
            end else begin
                res[n] = '{data: b, last: 1'b0};
                n++;
            end
        end
        if (last) begin
            esc_held = 2'd0;
            if (n > 0) begin
                res[n-1].last = 1'b1;
            end
        end
        for (int i = 0; i < n; i++) begin
            owed_q.push_back(res[i]);
        end
    endtask

    always @(posedge aclk) begin : watch
        out_byte_t want;
        if (!aresetn) begin
            decode_more = 1'b0;
            esc_held    = 2'd0;
            esc_digit   = 8'h00;
            owed_q.delete();
        end else begin
            if (cfg_we) begin
                decode_more = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                decode_transfer(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                if (owed_q.size() == 0) begin
                    $display("%0t: unexpected transfer: expected none, %s%02h last=%b",
                             $time, "actual data=", m_tdata, m_tlast);
                    mismatch_count++;
                end else begin
                    want = owed_q.pop_front();
                    if (m_tdata !== want.data || m_tlast !== want.last) begin
                        $display("%0t: mismatch: expected data=%02h last=%b, %s%02h last=%b",
                                 $time, want.data, want.last, "actual data=",
                                 m_tdata, m_tlast);
                        mismatch_count++;
                    end
                end
            end
        end
        results_owed = owed_q.size();
    end

endmodule

// File: bench/selective_percent_decoder_tb.sv
module selective_percent_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 200000;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       cfg_we;
    logic       cfg_wdata;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;

    int mismatch_count;
    int results_owed;
    int bytes_sent  = 0;
    int tx_idle_pct = 24;
    int rx_idle_pct = 24;
    int cycle_count = 0;
    bit hold_off_req = 1'b0;

    always #5 aclk = ~aclk;

    selective_percent_decoder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    selective_percent_decoder_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .mismatch_count(mismatch_count),
        .results_owed  (results_owed)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_text(input string t);
        for (int i = 0; i < t.len(); i++) begin
            send_byte(t[i], i == t.len() - 1);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_mode(input logic more);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= more;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) begin
            return 8'h30 + 8'(v);
        end
        return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    task automatic run_phase(input int count);
        logic [7:0] str_q[$];
        logic [7:0] val;
        int         target;
        int         len;
        int         r;
        target = bytes_sent + count;
        while (bytes_sent < target) begin
            str_q.delete();
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
                r = $urandom_range(99);
                if (r < 55) begin
                    val = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                   : 8'($urandom_range(127));
                    str_q.push_back(spd_pkg::PctChar);
                    str_q.push_back(hex_char(val[7:4]));
                    str_q.push_back(hex_char(val[3:0]));
                end else if (r < 65) begin
                    str_q.push_back(spd_pkg::PctChar);
                end else if (r < 85) begin
                    str_q.push_back(8'($urandom_range(8'h20, 8'h7e)));
                end else begin
                    str_q.push_back(8'($urandom_range(255)));
                end
            end
            if ($urandom_range(9) == 0 && str_q.size() > 1) begin
                void'(str_q.pop_back());
            end
            foreach (str_q[i]) begin
                send_byte(str_q[i], i == str_q.size() - 1);
            end
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        s_tlast   = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_text("%41%2f");
        send_text("%26%22%FF");
        send_text("%%4G");
        send_text("%4");
        send_text("%");
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);

        set_mode(1'b1);
        run_phase(100);

        set_mode(1'b0);
        hold_off_req = 1'b1;
        run_phase(100);

        set_mode(1'b1);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_phase(100);

        set_mode(1'b0);
        tx_idle_pct = 24;
        rx_idle_pct = 24;
        run_phase(100);

        drain();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && results_owed == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
